/* hdl/sitda_pkg.sv */
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII - shared package
// Types, character codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [3:0] PAD_LIMIT  = 4'd11;
   localparam int         PAD_BITS   = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_MEASURE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic convert;
      logic measure;
      logic emit;
      logic csr_write;
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic last;
   } status_type;

endpackage

/* hdl/sitda_ctrl.sv */
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII - controller
// Sequences load, binary to BCD conversion, length measurement and output of
// one character per word; owns the handshake of all three channels.
// ----------------------------------------------------------------------------
module sitda_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  sitda_pkg::status_type status,
   output sitda_pkg::cmd_type    cmd
);

   sitda_pkg::state_type state_ff;
   sitda_pkg::state_type state_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sitda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == sitda_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cmd           = '0;
      cmd.csr_write = csr_valid;
      unique case (state_ff)
         sitda_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sitda_pkg::ST_CONVERT;
            end
         end
         sitda_pkg::ST_CONVERT: begin
            cmd.convert = 1'b1;
            if (status.conv_done) begin
               state_in = sitda_pkg::ST_MEASURE;
            end
         end
         sitda_pkg::ST_MEASURE: begin
            cmd.measure = 1'b1;
            state_in    = sitda_pkg::ST_EMIT;
         end
         sitda_pkg::ST_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.last) begin
                  state_in = sitda_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sitda_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/sitda_datapath.sv */
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII - datapath
// Magnitude register, shift-and-add-3 BCD converter, digit count, padding
// count, configuration register and the output word register.
// ----------------------------------------------------------------------------
module sitda_datapath #(
   parameter int VALUE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sitda_pkg::cmd_type                 cmd,
   output sitda_pkg::status_type              status,
   input  logic [VALUE_BITS-1:0]              value,
   input  logic [sitda_pkg::PAD_BITS-1:0]     csr_data,
   output logic [7:0]                         char_code,
   output logic                               last_char
);

   localparam int DIGITS  = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int DIG_W   = $clog2(DIGITS);
   localparam int PLACE_W = $clog2(DIGITS + 1);
   localparam int SUM_W   = PLACE_W + 2;
   localparam int CNT_W   = $clog2(VALUE_BITS);

   logic [sitda_pkg::PAD_BITS-1:0] pad_width_ff;
   logic [VALUE_BITS-1:0]          mag_ff;
   logic [VALUE_BITS-1:0]          mag_in;
   logic [CNT_W-1:0]               cnt_ff;
   logic [CNT_W-1:0]               cnt_in;
   logic [3:0]                     bcd_ff [DIGITS];
   logic [3:0]                     bcd_in [DIGITS];
   logic [3:0]                     bcd_adj [DIGITS];
   logic                           sign_ff;
   logic                           sign_in;
   logic [PLACE_W-1:0]             place_ff;
   logic [PLACE_W-1:0]             place_in;
   logic [PLACE_W-1:0]             place_new;
   logic [PLACE_W-1:0]             place_m1;
   logic [sitda_pkg::PAD_BITS-1:0] pad_ff;
   logic [sitda_pkg::PAD_BITS-1:0] pad_in;
   logic [sitda_pkg::PAD_BITS-1:0] pad_sat;
   logic [SUM_W-1:0]               text_w;
   logic [7:0]                     char_ff;
   logic [7:0]                     char_in;
   logic                           last_ff;
   logic                           last_in;
   logic                           is_last;
   logic [3:0]                     digit_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_width_ff <= '0;
      end else if (cmd.csr_write) begin
         pad_width_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      cnt_ff   <= cnt_in;
      bcd_ff   <= bcd_in;
      sign_ff  <= sign_in;
      place_ff <= place_in;
      pad_ff   <= pad_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign place_m1  = place_ff - 1'b1;
   assign digit_sel = bcd_ff[place_m1[DIG_W-1:0]];
   assign is_last   = !sign_ff && (pad_ff == '0) && (place_ff == PLACE_W'(1));
   assign pad_sat   = (pad_width_ff > sitda_pkg::PAD_LIMIT) ? sitda_pkg::PAD_LIMIT
                                                              : pad_width_ff;
   assign text_w    = SUM_W'(place_new) + SUM_W'(sign_ff);

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      place_new = PLACE_W'(1);
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            place_new = PLACE_W'(i + 1);
         end
      end
   end

   always_comb begin
      mag_in   = mag_ff;
      cnt_in   = cnt_ff;
      bcd_in   = bcd_ff;
      sign_in  = sign_ff;
      place_in = place_ff;
      pad_in   = pad_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         sign_in = value[VALUE_BITS-1];
         mag_in  = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
         cnt_in  = CNT_W'(VALUE_BITS - 1);
         for (int i = 0; i < DIGITS; i++) begin
            bcd_in[i] = 4'd0;
         end
      end
      if (cmd.convert) begin
         bcd_in[0] = {bcd_adj[0][2:0], mag_ff[VALUE_BITS-1]};
         for (int i = 1; i < DIGITS; i++) begin
            bcd_in[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
         end
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.measure) begin
         place_in = place_new;
         pad_in   = (SUM_W'(pad_sat) > text_w)
                    ? sitda_pkg::PAD_BITS'(SUM_W'(pad_sat) - text_w) : '0;
      end
      if (cmd.emit) begin
         last_in = is_last;
         priority if (sign_ff) begin
            char_in = sitda_pkg::CHAR_MINUS;
            sign_in = 1'b0;
         end else if (pad_ff != '0) begin
            char_in = sitda_pkg::CHAR_ZERO;
            pad_in  = pad_ff - 1'b1;
         end else begin
            char_in  = sitda_pkg::CHAR_ZERO + {4'd0, digit_sel};
            place_in = place_m1;
         end
      end
   end

   assign status.conv_done = (cnt_ff == '0);
   assign status.last      = is_last;
   assign char_code        = char_ff;
   assign last_char        = last_ff;

endmodule

/* hdl/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII converter
// Emits the decimal text of a signed integer, one ASCII character per word,
// with optional zero padding after the sign.
//
//   Channel  Direction  Content
//   req_     in         value (VALUE_BITS, signed) in req_tdata
//   rsp_     out        char_code in rsp_tdata, last_char in rsp_tlast
//   csr_     in         pad_width in csr_data[3:0]
//
// One item takes a load step, VALUE_BITS shifts of shift-and-add-3 BCD
// conversion, a measure step and one character per word (up to 11 for
// 32 bits), each character waiting while the output is stalled.
// The BCD shift loop sets the fixed part of that sequence.
// A new item is taken as soon as the last character sits in the output
// register. Reset is synchronous and clears the controller and pad_width.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((VALUE_BITS + 7) / 8)*8-1:0] req_tdata,   // value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // char_code
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sitda_pkg::PAD_BITS-1:0]      csr_data
);

   sitda_pkg::cmd_type    cmd;
   sitda_pkg::status_type status;

   sitda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .status     (status),
      .cmd        (cmd)
   );

   sitda_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .value     (req_tdata[VALUE_BITS-1:0]),
      .csr_data  (csr_data),
      .char_code (rsp_tdata),
      .last_char (rsp_tlast)
   );

   a_char_set : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == sitda_pkg::CHAR_MINUS) ||
                     ((rsp_tdata >= sitda_pkg::CHAR_ZERO) && (rsp_tdata <= 8'd57)))
      else $error("output word is neither a minus sign nor a digit");

   a_minus_not_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata == sitda_pkg::CHAR_MINUS)) |-> !rsp_tlast)
      else $error("minus sign flagged as last character");

   a_ready_after_last : assert property (@(posedge clock) disable iff (reset)
      $rose(req_tready) |-> (rsp_tvalid && rsp_tlast))
      else $error("input reopened before the last character was loaded");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (!req_tready && !rsp_tvalid) ||
                                     (!req_tready && $past(rsp_tvalid)))
      else $error("input accepted while a conversion was running");

endmodule
